// File: hw/rtl/fat_chain_allocator_defines.svh
// Assertion macros for the chain allocator checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FAT_CHAIN_ALLOCATOR_DEFINES_SVH
`define FAT_CHAIN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fat_chain_allocator: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define FCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fat_chain_allocator: next-cycle check failed");

`endif

// File: hw/rtl/fca_pkg.sv
// Shared types and constants of the chain allocator.
// No dependencies; used by every module of the block.
package fca_pkg;

  localparam int LINK_W    = 16;
  localparam int CMP_W     = 17;
  localparam int REQ_W     = 3;
  localparam int NODE_IN_W = 10;
  localparam int STEP_W    = 10;
  localparam int RES_W     = 11;
  localparam int STATUS_W  = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_EXTEND  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_NTH     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TRUNC   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Link table marks
  localparam logic [LINK_W-1:0] EOC_MARK  = 16'hFFFF;
  localparam logic [LINK_W-1:0] FREE_MARK = 16'h0000;

  // Result value for end of chain or error
  localparam logic [RES_W-1:0] NO_NODE = 11'h7FF;

  // Classification of one link word from the compare unit
  typedef struct packed {
    logic is_eoc;
    logic is_free;
    logic in_range;
    logic probe_below;
  } link_class_t;

endpackage

// File: hw/rtl/fat_chain_allocator.sv
// Chain allocator top level: sequencer around the link table and compare unit.
// Depends on fca_pkg, fca_link_mem and fca_link_unit. After reset a clearing pass
// over the whole table runs with busy high. One request at a time, busy high while
// it runs; create scans for a free entry, extend walks the chain and then scans,
// get nth follows links, truncate caps the chain and frees nodes, destroy frees nodes.
// The result shows on out_valid the cycle after the request ends; the receiver cannot stall it.
module fat_chain_allocator #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [fca_pkg::REQ_W-1:0]           in_req_type,
  input  logic [fca_pkg::NODE_IN_W-1:0]       in_chain_node,
  input  logic [fca_pkg::STEP_W-1:0]          in_step_count,
  output logic                                busy,
  output logic                                out_valid,
  output logic signed [fca_pkg::RES_W-1:0]    out_node_result,
  output logic [fca_pkg::STATUS_W-1:0]        out_status
);

  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CW          = fca_pkg::CMP_W;
  localparam int ALLOC_LIMIT = (TABLE_DEPTH > 65535) ? 65535 : TABLE_DEPTH;
  localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LIMIT_C   = CW'(ALLOC_LIMIT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_NTH   = 4'd4;
  localparam logic [3:0] S_TRUNC = 4'd5;
  localparam logic [3:0] S_DES   = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_LINK  = 4'd8;

  logic [3:0]                   state_r, state_nxt;
  logic [AW-1:0]                hint_r, hint_nxt;
  logic [fca_pkg::REQ_W-1:0]    req_r, req_nxt;
  logic [CW-1:0]                node_r, node_nxt;
  logic [AW-1:0]                last_r, last_nxt;
  logic [AW-1:0]                found_r, found_nxt;
  logic [AW-1:0]                cnt_r, cnt_nxt;
  logic [fca_pkg::STEP_W-1:0]   steps_r, steps_nxt;
  logic                         out_valid_r;
  logic [fca_pkg::RES_W-1:0]    out_res_r;
  logic [fca_pkg::STATUS_W-1:0] out_status_r;

  logic                         fin;
  logic [fca_pkg::RES_W-1:0]    fin_res;
  logic [fca_pkg::STATUS_W-1:0] fin_status;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [fca_pkg::LINK_W-1:0]   mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [fca_pkg::LINK_W-1:0]   mem_rdata;

  fca_pkg::link_class_t         cls;

  logic [CW-1:0]                cn_ext;
  logic                         cn_ok;
  logic                         cn_nz;
  logic [CW-1:0]                hint_ext;
  logic [CW-1:0]                hint_inc;
  logic [CW-1:0]                node_inc;
  logic [CW-1:0]                rdata_ext;

  fca_link_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fca_link_unit #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_unit (
    .word  (mem_rdata),
    .probe (node_r[AW-1:0]),
    .hint  (hint_r),
    .cls   (cls)
  );

  // Widen request and state fields for range compares
  assign cn_ext    = CW'(in_chain_node);
  assign cn_ok     = (cn_ext < DEPTH_C);
  assign cn_nz     = (in_chain_node != '0);
  assign hint_ext  = CW'(hint_r);
  assign hint_inc  = hint_ext + CW'(1);
  assign node_inc  = node_r + CW'(1);
  assign rdata_ext = CW'(mem_rdata);

  // Sequencer: the scan, walk, nth, truncate and destroy states consume the read issued the cycle before
  always_comb begin
    state_nxt  = state_r;
    hint_nxt   = hint_r;
    req_nxt    = req_r;
    node_nxt   = node_r;
    last_nxt   = last_r;
    found_nxt  = found_r;
    cnt_nxt    = cnt_r;
    steps_nxt  = steps_r;
    fin        = 1'b0;
    fin_res    = fca_pkg::NO_NODE;
    fin_status = fca_pkg::ST_BAD_NODE;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = fca_pkg::FREE_MARK;
    mem_raddr  = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        if (cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          steps_nxt = in_step_count;
          case (in_req_type)
            fca_pkg::REQ_CREATE: begin
              if (hint_inc >= LIMIT_C) begin
                fin        = 1'b1;
                fin_status = fca_pkg::ST_FULL;
              end else begin
                node_nxt  = hint_inc;
                mem_raddr = hint_inc[AW-1:0];
                state_nxt = S_SCAN;
              end
            end
            fca_pkg::REQ_EXTEND: begin
              if (cn_nz && cn_ok) begin
                node_nxt  = cn_ext;
                mem_raddr = cn_ext[AW-1:0];
                cnt_nxt   = '0;
                state_nxt = S_WALK;
              end else begin
                fin = 1'b1;
              end
            end
            fca_pkg::REQ_NTH: begin
              if (!cn_ok) begin
                fin = 1'b1;
              end else if (in_step_count == '0) begin
                fin        = 1'b1;
                fin_res    = cn_ext[fca_pkg::RES_W-1:0];
                fin_status = fca_pkg::ST_OK;
              end else begin
                node_nxt  = cn_ext;
                mem_raddr = cn_ext[AW-1:0];
                state_nxt = S_NTH;
              end
            end
            fca_pkg::REQ_TRUNC: begin
              if (cn_nz && cn_ok) begin
                node_nxt  = cn_ext;
                mem_raddr = cn_ext[AW-1:0];
                state_nxt = S_TRUNC;
              end else begin
                fin = 1'b1;
              end
            end
            fca_pkg::REQ_DESTROY: begin
              if (cn_nz && cn_ok) begin
                node_nxt  = cn_ext;
                mem_raddr = cn_ext[AW-1:0];
                state_nxt = S_DES;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Search upward for the next free entry
      S_SCAN: begin
        if (cls.is_free) begin
          found_nxt = node_r[AW-1:0];
          state_nxt = S_ALLOC;
        end else if (node_inc >= LIMIT_C) begin
          fin        = 1'b1;
          fin_status = fca_pkg::ST_FULL;
          state_nxt  = S_IDLE;
        end else begin
          node_nxt  = node_inc;
          mem_raddr = node_inc[AW-1:0];
        end
      end

      // Follow the chain to its last node, then allocate
      S_WALK: begin
        if (cls.is_eoc) begin
          last_nxt = node_r[AW-1:0];
          if (hint_inc >= LIMIT_C) begin
            fin        = 1'b1;
            fin_status = fca_pkg::ST_FULL;
            state_nxt  = S_IDLE;
          end else begin
            node_nxt  = hint_inc;
            mem_raddr = hint_inc[AW-1:0];
            state_nxt = S_SCAN;
          end
        end else if (cls.is_free || !cls.in_range || (cnt_r == LAST_ADDR)) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          node_nxt  = rdata_ext;
          mem_raddr = rdata_ext[AW-1:0];
        end
      end

      // Hand out the hint node; extend links the old tail to it first
      S_ALLOC: begin
        mem_we = 1'b1;
        if (req_r == fca_pkg::REQ_EXTEND) begin
          mem_waddr = last_r;
          mem_wdata = fca_pkg::LINK_W'(hint_r);
          state_nxt = S_LINK;
        end else begin
          mem_waddr  = hint_r;
          mem_wdata  = fca_pkg::EOC_MARK;
          hint_nxt   = found_r;
          fin        = 1'b1;
          fin_res    = hint_ext[fca_pkg::RES_W-1:0];
          fin_status = fca_pkg::ST_OK;
          state_nxt  = S_IDLE;
        end
      end

      S_LINK: begin
        mem_we     = 1'b1;
        mem_waddr  = hint_r;
        mem_wdata  = fca_pkg::EOC_MARK;
        hint_nxt   = found_r;
        fin        = 1'b1;
        fin_res    = hint_ext[fca_pkg::RES_W-1:0];
        fin_status = fca_pkg::ST_OK;
        state_nxt  = S_IDLE;
      end

      // Follow links for get nth
      S_NTH: begin
        if (cls.is_eoc) begin
          fin        = 1'b1;
          fin_status = fca_pkg::ST_OK;
          state_nxt  = S_IDLE;
        end else if (!cls.in_range) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else if (steps_r == fca_pkg::STEP_W'(1)) begin
          fin        = 1'b1;
          fin_res    = mem_rdata[fca_pkg::RES_W-1:0];
          fin_status = fca_pkg::ST_OK;
          state_nxt  = S_IDLE;
        end else begin
          steps_nxt = steps_r - fca_pkg::STEP_W'(1);
          node_nxt  = rdata_ext;
          mem_raddr = rdata_ext[AW-1:0];
        end
      end

      // Cap the chain at the node, then free the rest
      S_TRUNC: begin
        if (cls.is_free) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = node_r[AW-1:0];
          mem_wdata = fca_pkg::EOC_MARK;
          if (cls.is_eoc || !cls.in_range) begin
            fin        = 1'b1;
            fin_res    = '0;
            fin_status = fca_pkg::ST_OK;
            state_nxt  = S_IDLE;
          end else begin
            node_nxt  = rdata_ext;
            mem_raddr = rdata_ext[AW-1:0];
            state_nxt = S_DES;
          end
        end
      end

      // Release one node per cycle and lower the hint
      S_DES: begin
        mem_we    = 1'b1;
        mem_waddr = node_r[AW-1:0];
        mem_wdata = fca_pkg::FREE_MARK;
        if (cls.probe_below) begin
          hint_nxt = node_r[AW-1:0];
        end
        if (cls.is_eoc || cls.is_free || !cls.in_range) begin
          fin        = 1'b1;
          fin_res    = '0;
          fin_status = fca_pkg::ST_OK;
          state_nxt  = S_IDLE;
        end else begin
          node_nxt  = rdata_ext;
          mem_raddr = rdata_ext[AW-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      hint_r      <= AW'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= fin;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    node_r  <= node_nxt;
    last_r  <= last_nxt;
    found_r <= found_nxt;
    steps_r <= steps_nxt;
    if (fin) begin
      out_res_r    <= fin_res;
      out_status_r <= fin_status;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_node_result = out_res_r;
  assign out_status      = out_status_r;

endmodule

// File: hw/rtl/fca_link_mem.sv
// Link table storage: one write port, one registered read port, write-first.
// Depends on fca_pkg for the link word width.
module fca_link_mem #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [fca_pkg::LINK_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [fca_pkg::LINK_W-1:0] rdata
);

  logic [fca_pkg::LINK_W-1:0] mem [TABLE_DEPTH];
  logic [fca_pkg::LINK_W-1:0] rdata_r;

  // Write, then read with bypass of a write to the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/fca_link_unit.sv
// Shared compare unit: classifies a link word and compares a node with the hint.
// Depends on fca_pkg for link_class_t and the link marks.
module fca_link_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = 10
) (
  input  logic [fca_pkg::LINK_W-1:0] word,
  input  logic [AW-1:0]              probe,
  input  logic [AW-1:0]              hint,
  output fca_pkg::link_class_t       cls
);

  localparam logic [fca_pkg::CMP_W-1:0] DEPTH_C = fca_pkg::CMP_W'(TABLE_DEPTH);

  // Decode end of chain, free and range; compare probe against hint
  always_comb begin
    cls.is_eoc      = (word == fca_pkg::EOC_MARK);
    cls.is_free     = (word == fca_pkg::FREE_MARK);
    cls.in_range    = (fca_pkg::CMP_W'(word) < DEPTH_C);
    cls.probe_below = (probe < hint);
  end

endmodule

// File: hw/rtl/fca_checker.sv
// Port-level checks of the chain allocator, bound to the top level.
// Depends on fca_pkg and fat_chain_allocator_defines.svh.
`include "fat_chain_allocator_defines.svh"

module fca_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [fca_pkg::RES_W-1:0]    out_node_result,
  input logic [fca_pkg::STATUS_W-1:0]        out_status
);

  // A failed request reports no node
  `FCA_ASSERT_IMP(a_err_no_node, out_valid && (out_status != fca_pkg::ST_OK), out_node_result == fca_pkg::NO_NODE)

  // An accepted request either answers at once or keeps the block busy
  `FCA_ASSERT_NXT(a_accept_moves, start && !busy, busy || out_valid)

  // A result only shows once the block has finished the request
  `FCA_ASSERT_IMP(a_result_idle, out_valid, !busy)

  // The clearing pass holds requests off right after reset
  `FCA_ASSERT_IMP(a_clear_after_reset, !$past(rst_n), busy)

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_node_result (out_node_result),
  .out_status      (out_status)
);

// File: tb/fat_chain_allocator_test.sv
// Self-checking bench for the FAT-style chain allocator: directed and random requests
// are checked result by result against fixed results or a link-table model in the bench.
// Depends on fca_pkg and fat_chain_allocator; needs no files or arguments.
module fat_chain_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH     = 1024;
  localparam int ALLOC_LIMIT     = (TABLE_DEPTH > 65535) ? 65535 : TABLE_DEPTH;
  localparam int RANDOM_REQUESTS = 120;
  localparam int FILL_AT         = 60;
  localparam int FULL_TARGET     = 6;
  localparam int QUIET_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int N_DIRECTED      = 25;

  // Request codes the block does not serve
  localparam logic [fca_pkg::REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [fca_pkg::REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [fca_pkg::RES_W-1:0]    node_result;
    logic [fca_pkg::STATUS_W-1:0] status;
  } node_reply_t;

  typedef struct packed {
    logic [fca_pkg::REQ_W-1:0]     req;
    logic [fca_pkg::NODE_IN_W-1:0] node;
    logic [fca_pkg::STEP_W-1:0]    steps;
    logic                          fixed;
    logic [fca_pkg::RES_W-1:0]     node_result;
    logic [fca_pkg::STATUS_W-1:0]  status;
  } stim_row_t;

  // Directed requests; rows with fixed set carry their result, the rest use the model
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{fca_pkg::REQ_CREATE,  10'd0,    10'd0,    1'b1, 11'd1,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_CREATE,  10'd1023, 10'd1023, 1'b1, 11'd2,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_EXTEND,  10'd1,    10'd0,    1'b1, 11'd3,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_EXTEND,  10'd1,    10'd0,    1'b1, 11'd4,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_NTH,     10'd1,    10'd0,    1'b1, 11'd1,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_NTH,     10'd1,    10'd2,    1'b1, 11'd4,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_NTH,     10'd1,    10'd3,    1'b1, fca_pkg::NO_NODE, fca_pkg::ST_OK},
    '{fca_pkg::REQ_NTH,     10'd1,    10'd1023, 1'b1, fca_pkg::NO_NODE, fca_pkg::ST_OK},
    '{fca_pkg::REQ_NTH,     10'd0,    10'd5,    1'b1, 11'd0,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_NTH,     10'd1023, 10'd1,    1'b1, 11'd0,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_NTH,     10'd1023, 10'd0,    1'b1, 11'd1023, fca_pkg::ST_OK},
    '{fca_pkg::REQ_EXTEND,  10'd0,    10'd0,    1'b1, fca_pkg::NO_NODE, fca_pkg::ST_BAD_NODE},
    '{fca_pkg::REQ_EXTEND,  10'd1023, 10'd0,    1'b1, fca_pkg::NO_NODE, fca_pkg::ST_BAD_NODE},
    '{fca_pkg::REQ_TRUNC,   10'd0,    10'd0,    1'b1, fca_pkg::NO_NODE, fca_pkg::ST_BAD_NODE},
    '{fca_pkg::REQ_TRUNC,   10'd1023, 10'd0,    1'b1, fca_pkg::NO_NODE, fca_pkg::ST_BAD_NODE},
    '{fca_pkg::REQ_DESTROY, 10'd0,    10'd0,    1'b1, fca_pkg::NO_NODE, fca_pkg::ST_BAD_NODE},
    '{fca_pkg::REQ_DESTROY, 10'd1023, 10'd0,    1'b1, 11'd0,    fca_pkg::ST_OK},
    '{REQ_UNUSED_LO,        10'd1,    10'd1,    1'b1, fca_pkg::NO_NODE, fca_pkg::ST_BAD_NODE},
    '{REQ_UNUSED_HI,        10'd1023, 10'd1023, 1'b1, fca_pkg::NO_NODE, fca_pkg::ST_BAD_NODE},
    '{fca_pkg::REQ_TRUNC,   10'd3,    10'd0,    1'b1, 11'd0,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_DESTROY, 10'd3,    10'd0,    1'b1, 11'd0,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_EXTEND,  10'd1,    10'd0,    1'b1, fca_pkg::NO_NODE, fca_pkg::ST_BAD_NODE},
    '{fca_pkg::REQ_NTH,     10'd1,    10'd2,    1'b0, 11'd0,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_CREATE,  10'd0,    10'd0,    1'b0, 11'd0,    fca_pkg::ST_OK},
    '{fca_pkg::REQ_TRUNC,   10'd1,    10'd0,    1'b0, 11'd0,    fca_pkg::ST_OK}
  };

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic [fca_pkg::REQ_W-1:0]     in_req_type;
  logic [fca_pkg::NODE_IN_W-1:0] in_chain_node;
  logic [fca_pkg::STEP_W-1:0]    in_step_count;
  logic                          busy;
  logic                          out_valid;
  logic signed [fca_pkg::RES_W-1:0] out_node_result;
  logic [fca_pkg::STATUS_W-1:0]  out_status;

  // Model state: link table and lowest free node
  logic [fca_pkg::LINK_W-1:0] link_tbl [TABLE_DEPTH];
  int unsigned       lowest_free;

  node_reply_t       awaited_replies [$];
  node_reply_t       oldest_reply;
  int unsigned       live_heads [$];
  int                status_tally [4];
  int                requests_sent;
  int                fill_requests;
  int                results_compared;
  int                fail_count = 0;
  int                burst_left;
  int                quiet_cycles = 0;

  fat_chain_allocator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_req_type     (in_req_type),
    .in_chain_node   (in_chain_node),
    .in_step_count   (in_step_count),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_node_result (out_node_result),
    .out_status      (out_status)
  );

  always #2 clk = ~clk;

  // Take the lowest free node, provided a further free node exists above it
  function automatic bit take_free_node(output int unsigned node);
    int unsigned k;
    node = 0;
    if (lowest_free == 0 || lowest_free >= ALLOC_LIMIT) return 1'b0;
    for (k = lowest_free + 1; k < ALLOC_LIMIT; k++) begin
      if (link_tbl[k] == fca_pkg::FREE_MARK) break;
    end
    if (k >= ALLOC_LIMIT) return 1'b0;
    node = lowest_free;
    link_tbl[lowest_free] = fca_pkg::EOC_MARK;
    lowest_free = k;
    return 1'b1;
  endfunction

  // Free nodes from here to end of chain, stopping early at a free entry
  function automatic void free_chain_from(input int unsigned from);
    int unsigned node;
    int unsigned nxt;
    node = from;
    for (int guard = 0; guard <= TABLE_DEPTH; guard++) begin
      if (node == 0 || node >= TABLE_DEPTH) return;
      nxt = link_tbl[node];
      link_tbl[node] = fca_pkg::FREE_MARK;
      if (node < lowest_free) lowest_free = node;
      if (nxt == fca_pkg::EOC_MARK) return;
      node = nxt;
    end
  endfunction

  function automatic bit is_live(input int unsigned node);
    return node != 0 && node < TABLE_DEPTH && link_tbl[node] != fca_pkg::FREE_MARK;
  endfunction

  // Serve one request on the model table and give the result it should produce
  function automatic void apply_chain_request(input logic [fca_pkg::REQ_W-1:0] rq,
                                              input logic [fca_pkg::NODE_IN_W-1:0] cn,
                                              input logic [fca_pkg::STEP_W-1:0] steps,
                                              output logic [fca_pkg::RES_W-1:0] res,
                                              output logic [fca_pkg::STATUS_W-1:0] st);
    int unsigned node;
    int unsigned last;
    int unsigned nxt;
    bit          found;
    res = fca_pkg::NO_NODE;
    st  = fca_pkg::ST_BAD_NODE;
    case (rq)
      fca_pkg::REQ_CREATE: begin
        if (take_free_node(node)) begin
          res = fca_pkg::RES_W'(node);
          st  = fca_pkg::ST_OK;
        end else begin
          st = fca_pkg::ST_FULL;
        end
      end
      fca_pkg::REQ_EXTEND: begin
        if (is_live(cn)) begin
          last  = cn;
          found = 1'b0;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            nxt = link_tbl[last];
            if (nxt == fca_pkg::EOC_MARK) begin
              found = 1'b1;
              break;
            end
            if (nxt == 0 || nxt >= TABLE_DEPTH) break;
            last = nxt;
          end
          if (found) begin
            if (take_free_node(node)) begin
              link_tbl[last] = fca_pkg::LINK_W'(node);
              res = fca_pkg::RES_W'(node);
              st  = fca_pkg::ST_OK;
            end else begin
              st = fca_pkg::ST_FULL;
            end
          end
        end
      end
      fca_pkg::REQ_NTH: begin
        node = cn;
        for (int i = 0; i < steps && node != fca_pkg::EOC_MARK; i++) begin
          if (node >= TABLE_DEPTH) break;
          node = link_tbl[node];
        end
        if (node == fca_pkg::EOC_MARK) begin
          st = fca_pkg::ST_OK;
        end else if (node < TABLE_DEPTH) begin
          res = fca_pkg::RES_W'(node);
          st  = fca_pkg::ST_OK;
        end
      end
      fca_pkg::REQ_TRUNC: begin
        if (is_live(cn)) begin
          nxt = link_tbl[cn];
          link_tbl[cn] = fca_pkg::EOC_MARK;
          if (nxt != fca_pkg::EOC_MARK) free_chain_from(nxt);
          res = '0;
          st  = fca_pkg::ST_OK;
        end
      end
      fca_pkg::REQ_DESTROY: begin
        if (cn != 0 && cn < TABLE_DEPTH) begin
          free_chain_from(cn);
          res = '0;
          st  = fca_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  endfunction

  // Follow up to max_links valid links from head
  function automatic void walk_chain(input int unsigned head, input int max_links,
                                     output int unsigned last, output int links);
    int unsigned nxt;
    last  = head;
    links = 0;
    while (links < max_links && last != 0 && last < TABLE_DEPTH) begin
      nxt = link_tbl[last];
      if (nxt == 0 || nxt >= TABLE_DEPTH) break;
      last = nxt;
      links++;
    end
  endfunction

  // Present one request, hold it until taken, record its expected result, then pace
  task automatic issue_request(input logic [fca_pkg::REQ_W-1:0] rq,
                               input logic [fca_pkg::NODE_IN_W-1:0] cn,
                               input logic [fca_pkg::STEP_W-1:0] steps, input logic fixed,
                               input logic [fca_pkg::RES_W-1:0] fixed_res,
                               input logic [fca_pkg::STATUS_W-1:0] fixed_st);
    node_reply_t reply;
    logic [fca_pkg::RES_W-1:0]    res;
    logic [fca_pkg::STATUS_W-1:0] st;
    start         <= 1'b1;
    in_req_type   <= rq;
    in_chain_node <= cn;
    in_step_count <= steps;
    do @(posedge clk); while (busy !== 1'b0);
    apply_chain_request(rq, cn, steps, res, st);
    status_tally[st]++;
    requests_sent++;
    if (rq == fca_pkg::REQ_CREATE && st == fca_pkg::ST_OK) live_heads.push_back(int'(res));
    reply.node_result = fixed ? fixed_res : res;
    reply.status      = fixed ? fixed_st : st;
    awaited_replies.push_back(reply);
    // end of burst: drop start for a random gap, then pick the next burst length
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40))
        @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
    end
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // Everyday mix: mostly well-formed chain work, with some noise
  task automatic pick_everyday_request(output logic [fca_pkg::REQ_W-1:0] rq,
                                       output logic [fca_pkg::NODE_IN_W-1:0] cn,
                                       output logic [fca_pkg::STEP_W-1:0] steps);
    int          pick;
    int          hi;
    int          links;
    int unsigned head;
    int unsigned last;
    pick  = $urandom_range(0, 99);
    rq    = fca_pkg::REQ_CREATE;
    cn    = fca_pkg::NODE_IN_W'($urandom_range(0, TABLE_DEPTH - 1));
    steps = fca_pkg::STEP_W'($urandom_range(0, TABLE_DEPTH - 1));
    if (pick >= 92) begin
      rq = fca_pkg::REQ_W'($urandom_range(fca_pkg::REQ_CREATE, REQ_UNUSED_HI));
    end else if (pick >= 20 && live_heads.size() != 0) begin
      hi   = $urandom_range(0, live_heads.size() - 1);
      head = live_heads[hi];
      if (link_tbl[head] == fca_pkg::FREE_MARK) begin
        // stale head: forget it and create instead
        live_heads.delete(hi);
      end else begin
        walk_chain(head, TABLE_DEPTH, last, links);
        cn = fca_pkg::NODE_IN_W'(head);
        if (pick < 48 && links < 12) begin
          rq = fca_pkg::REQ_EXTEND;
        end else if (pick < 48 || pick >= 78) begin
          rq = fca_pkg::REQ_DESTROY;
          // now and then cut from inside the chain, leaving a dangling link
          if (links > 0 && $urandom_range(0, 4) == 0) begin
            walk_chain(head, $urandom_range(1, links), last, links);
            cn = fca_pkg::NODE_IN_W'(last);
          end else begin
            live_heads.delete(hi);
          end
        end else if (pick < 68) begin
          rq    = fca_pkg::REQ_NTH;
          steps = ($urandom_range(0, 15) == 0) ?
                  fca_pkg::STEP_W'($urandom_range(0, TABLE_DEPTH - 1)) :
                  fca_pkg::STEP_W'($urandom_range(0, links + 2));
        end else begin
          rq = fca_pkg::REQ_TRUNC;
          walk_chain(head, $urandom_range(0, links), last, links);
          cn = fca_pkg::NODE_IN_W'(last);
        end
      end
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        $error("unexpected result: node_result %0d status %0d", out_node_result, out_status);
        fail_count++;
      end else begin
        oldest_reply = awaited_replies.pop_front();
        results_compared++;
        if (out_node_result !== oldest_reply.node_result) begin
          $error("node_result mismatch: expected %0d, actual %0d",
                 $signed(oldest_reply.node_result), out_node_result);
          fail_count++;
        end
        if (out_status !== oldest_reply.status) begin
          $error("status mismatch: expected %0d, actual %0d", oldest_reply.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // Abort if nothing is taken or returned for too long
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [fca_pkg::REQ_W-1:0]     rq;
    logic [fca_pkg::NODE_IN_W-1:0] cn;
    logic [fca_pkg::STEP_W-1:0]    steps;
    int                   pick;
    int                   full_goal;
    int unsigned          head;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_req_type   <= fca_pkg::REQ_CREATE;
    in_chain_node <= '0;
    in_step_count <= '0;
    burst_left    = 1;
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (link_tbl[i]) link_tbl[i] = fca_pkg::FREE_MARK;
    lowest_free = 1;

    // Reset, then wait out the clearing pass
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // Directed table
    for (int n = 0; n < N_DIRECTED; n++) begin
      issue_request(DIRECTED_ROWS[n].req, DIRECTED_ROWS[n].node, DIRECTED_ROWS[n].steps,
                    DIRECTED_ROWS[n].fixed, DIRECTED_ROWS[n].node_result,
                    DIRECTED_ROWS[n].status);
    end
    hold_until_drained();

    // Random requests, with one episode that fills the table and empties it again
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == FILL_AT) begin
        full_goal = status_tally[fca_pkg::ST_FULL] + FULL_TARGET;
        while (status_tally[fca_pkg::ST_FULL] < full_goal) begin
          pick  = $urandom_range(0, 99);
          cn    = fca_pkg::NODE_IN_W'($urandom_range(0, TABLE_DEPTH - 1));
          steps = fca_pkg::STEP_W'($urandom_range(0, 8));
          rq    = fca_pkg::REQ_CREATE;
          if (live_heads.size() != 0 && pick >= 12) begin
            cn = fca_pkg::NODE_IN_W'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
            rq = (pick < 95) ? fca_pkg::REQ_EXTEND : fca_pkg::REQ_NTH;
          end
          issue_request(rq, cn, steps, 1'b0, '0, '0);
          fill_requests++;
        end
        while (live_heads.size() != 0) begin
          head = live_heads.pop_front();
          issue_request(fca_pkg::REQ_DESTROY, fca_pkg::NODE_IN_W'(head),
                        fca_pkg::STEP_W'($urandom_range(0, 1023)), 1'b0, '0, '0);
          fill_requests++;
        end
        hold_until_drained();
      end
      pick_everyday_request(rq, cn, steps);
      issue_request(rq, cn, steps, 1'b0, '0, '0);
    end

    // Let the last results come back, then allow for stray ones
    start <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d requests (%0d in the fill episode), %0d results compared",
             requests_sent, fill_requests, results_compared);
    $display("tb: outcomes ok %0d, bad node %0d, table full %0d",
             status_tally[fca_pkg::ST_OK], status_tally[fca_pkg::ST_BAD_NODE],
             status_tally[fca_pkg::ST_FULL]);
    if (fail_count == 0 && awaited_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
